[rtl/psdc_pkg.sv]
// ----------------------------------------------------------------------------
// psdc_pkg
// Shared types, status codes and scoring helpers for the password checker.
// ----------------------------------------------------------------------------
package psdc_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [2:0] WEAK_TOP   = 3'd2;
    localparam logic [2:0] MEDIUM_TOP = 3'd4;

    localparam logic [1:0] LVL_VERY_WEAK = 2'd0;
    localparam logic [1:0] LVL_WEAK      = 2'd1;
    localparam logic [1:0] LVL_MEDIUM    = 2'd2;
    localparam logic [1:0] LVL_STRONG    = 2'd3;

    typedef struct packed {
        logic lower;
        logic upper;
        logic digit;
        logic special;
    } flags_t;

    typedef struct packed {
        logic [2:0] score;
        logic [1:0] level;
        logic       blocked;
        logic       len_ok;
        flags_t     flags;
        logic [1:0] status;
    } res_t;

    function automatic flags_t classify(input logic [7:0] b);
        flags_t f;
        f = '0;
        if (b >= 8'h61 && b <= 8'h7a) begin
            f.lower = 1'b1;
        end else if (b >= 8'h41 && b <= 8'h5a) begin
            f.upper = 1'b1;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            f.digit = 1'b1;
        end else begin
            f.special = 1'b1;
        end
        return f;
    endfunction

    function automatic logic [2:0] count_criteria(input logic len_ok, input flags_t f);
        return 3'(len_ok) + 3'(f.lower) + 3'(f.upper) + 3'(f.digit) + 3'(f.special);
    endfunction

    function automatic logic [1:0] level_of(input logic [2:0] s);
        logic [1:0] l;
        if (s == 3'd0) begin
            l = LVL_VERY_WEAK;
        end else if (s <= WEAK_TOP) begin
            l = LVL_WEAK;
        end else if (s <= MEDIUM_TOP) begin
            l = LVL_MEDIUM;
        end else begin
            l = LVL_STRONG;
        end
        return l;
    endfunction

endpackage

[rtl/psdc_ram.sv]
// ----------------------------------------------------------------------------
// psdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module psdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/psdc_fifo.sv]
// ----------------------------------------------------------------------------
// psdc_fifo
// Two-entry job queue between the byte front end and the blocklist engine.
// ----------------------------------------------------------------------------
module psdc_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty,
    output logic         full
);

    logic [W-1:0] slot_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rptr_reg];
    assign empty    = (cnt_reg == 2'd0);
    assign full     = (cnt_reg == 2'd2);

endmodule

[rtl/psdc_front.sv]
// ----------------------------------------------------------------------------
// psdc_front
// Byte front end: tracks position and character classes, writes each byte within
// MAX_LEN to the candidate buffer and, while the blocklist is not full, to the
// next free blocklist slot, posts a job on the last byte.
// ----------------------------------------------------------------------------
module psdc_front
    import psdc_pkg::*;
#(
    parameter int MAX_LEN = 255,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7,
    parameter int POS_W   = 9,
    parameter int POS_A   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [7:0]             s_char_byte,
    input  logic                   s_last_byte,
    input  logic                   path_free,
    input  logic [CNT_W-1:0]       entry_count,
    input  logic                   entry_full,
    output logic                   cand_we,
    output logic [POS_A-1:0]       cand_waddr,
    output logic [7:0]             cand_wdata,
    output logic                   bl_we,
    output logic [IDX_W+POS_A-1:0] bl_waddr,
    output logic                   job_push,
    output logic                   job_req,
    output logic                   job_too_long,
    output logic [POS_W-1:0]       job_len,
    output flags_t                 job_flags
);

    logic [POS_W-1:0] pos_reg, pos_next;
    flags_t           flags_reg, flags_next;
    logic             accept, store;
    logic [POS_W-1:0] pos_inc;
    flags_t           flags_cur;

    assign s_ready = path_free;
    assign accept  = s_valid && s_ready;
    assign store   = (pos_reg < POS_W'(MAX_LEN));
    assign pos_inc = store ? pos_reg + POS_W'(1) : POS_W'(MAX_LEN + 1);
    assign flags_cur = store ? (flags_reg | classify(s_char_byte)) : flags_reg;

    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        if (accept) begin
            if (s_last_byte) begin
                pos_next   = '0;
                flags_next = '0;
            end else begin
                pos_next   = pos_inc;
                flags_next = flags_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
    end

    assign cand_we    = accept && store;
    assign cand_waddr = pos_reg[POS_A-1:0];
    assign cand_wdata = s_char_byte;
    // stage into the next free slot; it only counts once an insert commits
    assign bl_we      = accept && store && !entry_full;
    assign bl_waddr   = {entry_count[IDX_W-1:0], pos_reg[POS_A-1:0]};

    assign job_push     = accept && s_last_byte;
    assign job_req      = s_req_type;
    assign job_too_long = !store;
    assign job_len      = pos_inc;
    assign job_flags    = flags_cur;

endmodule

[rtl/psdc_back.sv]
// ----------------------------------------------------------------------------
// psdc_back
// Blocklist engine: commits inserts, walks stored entries for checks, scores
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module psdc_back
    import psdc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7,
    parameter int POS_W   = 9,
    parameter int POS_A   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_pop,
    input  logic                   job_req,
    input  logic                   job_too_long,
    input  logic [POS_W-1:0]       job_len,
    input  flags_t                 job_flags,
    input  logic [7:0]             min_length,
    output logic                   idle,
    output logic [CNT_W-1:0]       entry_count,
    output logic                   entry_full,
    output logic [POS_A-1:0]       cand_raddr,
    input  logic [7:0]             cand_rdata,
    output logic [IDX_W+POS_A-1:0] bl_raddr,
    input  logic [7:0]             bl_rdata,
    output logic                   m_valid,
    input  logic                   m_ready,
    output res_t                   m_res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LEN_RD   = 3'd1;
    localparam logic [2:0] S_LEN_CHK  = 3'd2;
    localparam logic [2:0] S_BYTE_RD  = 3'd3;
    localparam logic [2:0] S_BYTE_CHK = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;
    localparam int LW = (POS_W > 8) ? POS_W : 8;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [POS_A-1:0] i_reg, i_next;
    logic             blocked_reg, blocked_next;
    logic             req_reg, too_long_reg;
    logic [POS_W-1:0] len_reg;
    flags_t           flags_reg;
    logic             m_valid_reg, m_valid_next;
    res_t             res_reg, res_next;

    logic             load, commit, len_ok;
    logic [POS_W-1:0] len_rdata;
    logic [2:0]       crit;
    logic             last_entry;

    assign entry_full = (count_reg == CNT_W'(ENTRIES));
    assign load       = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign commit     = load && req_reg && !too_long_reg && !entry_full;
    assign len_ok     = (LW'(len_reg) >= LW'(min_length));
    assign crit       = count_criteria(len_ok, flags_reg);
    assign last_entry = (k_reg + CNT_W'(1) == count_reg);

    psdc_ram #(.WIDTH(POS_W), .DEPTH(2 ** IDX_W)) u_len_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (len_reg),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (len_rdata)
    );

    assign cand_raddr = i_reg;
    assign bl_raddr   = {k_reg[IDX_W-1:0], i_reg};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        blocked_next = blocked_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        job_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_pop      = 1'b1;
                    blocked_next = 1'b0;
                    k_next       = '0;
                    if (job_too_long || job_req || count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LEN_RD;
                    end
                end
            end
            S_LEN_RD: begin
                state_next = S_LEN_CHK;
            end
            S_LEN_CHK: begin
                if (len_rdata == len_reg) begin
                    i_next     = '0;
                    state_next = S_BYTE_RD;
                end else if (last_entry) begin
                    state_next = S_DONE;
                end else begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_LEN_RD;
                end
            end
            S_BYTE_RD: begin
                state_next = S_BYTE_CHK;
            end
            S_BYTE_CHK: begin
                if (bl_rdata != cand_rdata) begin
                    if (last_entry) begin
                        state_next = S_DONE;
                    end else begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_LEN_RD;
                    end
                end else if (POS_W'(i_reg) + POS_W'(1) == len_reg) begin
                    blocked_next = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    i_next     = i_reg + POS_A'(1);
                    state_next = S_BYTE_RD;
                end
            end
            S_DONE: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    res_next     = '0;
                    if (too_long_reg) begin
                        res_next.status = ST_TOO_LONG;
                    end else if (req_reg) begin
                        res_next.status = entry_full ? ST_FULL : ST_OK;
                    end else begin
                        res_next.score   = blocked_reg ? 3'd0 : crit;
                        res_next.level   = level_of(blocked_reg ? 3'd0 : crit);
                        res_next.blocked = blocked_reg;
                        res_next.len_ok  = len_ok;
                        res_next.flags   = flags_reg;
                        res_next.status  = ST_OK;
                    end
                    if (commit) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        blocked_reg <= blocked_next;
        res_reg     <= res_next;
        if (job_pop) begin
            req_reg      <= job_req;
            too_long_reg <= job_too_long;
            len_reg      <= job_len;
            flags_reg    <= job_flags;
        end
    end

    assign idle        = (state_reg == S_IDLE);
    assign entry_count = count_reg;
    assign m_valid     = m_valid_reg;
    assign m_res       = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count past store size");

    a_blocked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.blocked) |-> (res_reg.score == 3'd0))
        else $error("blocklisted result with nonzero score");

    a_byte_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BYTE_CHK) |-> (POS_W'(i_reg) < len_reg))
        else $error("byte compare past string length");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN_CHK) |-> (k_reg < count_reg))
        else $error("entry walk past stored entries");

endmodule

[rtl/password_strength_dictionary_check_top.sv]
// ----------------------------------------------------------------------------
// password_strength_dictionary_check_top
// Password strength meter with a blocklist of common passwords.
// ----------------------------------------------------------------------------
// Strings enter one byte per transaction, the final byte flagged by
// s_last_byte; each string gives one result on its final byte. A byte is taken
// while the job queue is empty and the engine is idle. A check walks the stored
// entries one at a time through single-port-read length and byte RAMs: a
// length read and compare per entry, then, in entries of the same length, a byte
// read and compare per byte up to a mismatch or a full match; an insert or an
// over-long string skips the walk. The next string's bytes are taken once that
// walk ends and its result has moved into the output register, even while that
// result still waits on m_ready; a result finished while the one before it
// still waits holds the engine, and the input, until m_ready frees the register.
module password_strength_dictionary_check_top
    import psdc_pkg::*;
#(
    parameter int BLOCKLIST_ENTRIES = 64,
    parameter int MAX_LEN           = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_char_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_score,
    output logic [1:0] m_strength_level,
    output logic       m_is_blocklisted,
    output logic       m_length_ok,
    output logic       m_has_lower,
    output logic       m_has_upper,
    output logic       m_has_digit,
    output logic       m_has_symbol,
    output logic [1:0] m_status
);

    localparam int IDX_W = (BLOCKLIST_ENTRIES > 1) ? $clog2(BLOCKLIST_ENTRIES) : 1;
    localparam int CNT_W = $clog2(BLOCKLIST_ENTRIES + 1);
    localparam int POS_W = $clog2(MAX_LEN + 2);
    localparam int POS_A = $clog2(MAX_LEN + 1);
    localparam int JOB_W = 2 + POS_W + $bits(flags_t);

    logic [7:0] min_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= 8'd8;
        end else if (cfg_we) begin
            min_length_reg <= cfg_wdata;
        end
    end

    logic                   cand_we, bl_we;
    logic [POS_A-1:0]       cand_waddr, cand_raddr;
    logic [7:0]             cand_wdata, cand_rdata, bl_rdata;
    logic [IDX_W+POS_A-1:0] bl_waddr, bl_raddr;
    logic                   f_push, f_req, f_too_long;
    logic [POS_W-1:0]       f_len;
    flags_t                 f_flags;
    logic                   b_req, b_too_long;
    logic [POS_W-1:0]       b_len;
    flags_t                 b_flags;
    logic [JOB_W-1:0]       q_out;
    logic                   q_empty, q_full, q_pop;
    logic                   back_idle, entry_full;
    logic [CNT_W-1:0]       entry_count;
    res_t                   res;

    psdc_front #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .POS_W   (POS_W),
        .POS_A   (POS_A)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_char_byte  (s_char_byte),
        .s_last_byte  (s_last_byte),
        .path_free    (q_empty && !q_full && back_idle),
        .entry_count  (entry_count),
        .entry_full   (entry_full),
        .cand_we      (cand_we),
        .cand_waddr   (cand_waddr),
        .cand_wdata   (cand_wdata),
        .bl_we        (bl_we),
        .bl_waddr     (bl_waddr),
        .job_push     (f_push),
        .job_req      (f_req),
        .job_too_long (f_too_long),
        .job_len      (f_len),
        .job_flags    (f_flags)
    );

    psdc_fifo #(.W(JOB_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_req, f_too_long, f_len, f_flags}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {b_req, b_too_long, b_len, b_flags} = q_out;

    psdc_ram #(.WIDTH(8), .DEPTH(2 ** POS_A)) u_cand_ram (
        .aclk  (aclk),
        .we    (cand_we),
        .waddr (cand_waddr),
        .wdata (cand_wdata),
        .raddr (cand_raddr),
        .rdata (cand_rdata)
    );

    psdc_ram #(.WIDTH(8), .DEPTH((2 ** IDX_W) * (2 ** POS_A))) u_bl_ram (
        .aclk  (aclk),
        .we    (bl_we),
        .waddr (bl_waddr),
        .wdata (cand_wdata),
        .raddr (bl_raddr),
        .rdata (bl_rdata)
    );

    psdc_back #(
        .ENTRIES (BLOCKLIST_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .POS_W   (POS_W),
        .POS_A   (POS_A)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (!q_empty),
        .job_pop      (q_pop),
        .job_req      (b_req),
        .job_too_long (b_too_long),
        .job_len      (b_len),
        .job_flags    (b_flags),
        .min_length   (min_length_reg),
        .idle         (back_idle),
        .entry_count  (entry_count),
        .entry_full   (entry_full),
        .cand_raddr   (cand_raddr),
        .cand_rdata   (cand_rdata),
        .bl_raddr     (bl_raddr),
        .bl_rdata     (bl_rdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res        (res)
    );

    assign m_score          = res.score;
    assign m_strength_level = res.level;
    assign m_is_blocklisted = res.blocked;
    assign m_length_ok      = res.len_ok;
    assign m_has_lower      = res.flags.lower;
    assign m_has_upper      = res.flags.upper;
    assign m_has_digit      = res.flags.digit;
    assign m_has_symbol     = res.flags.special;
    assign m_status         = res.status;

endmodule
